>>> rtl/slasm_pkg.sv
// Package for the serial line assembler: widths, result kind codes and the
// command and status bundles shared by the controller and the datapath.
// No dependencies.
package slasm_pkg;

   localparam int BUF_SIZE = 64;
   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 6;
   localparam int KIND_W   = 2;
   // Count of held characters, 0 .. BUF_SIZE-1.
   localparam int CNT_W    = $clog2(BUF_SIZE);
   // Two banks of the line store: one assembling, one holding a finished line.
   localparam int ADDR_W   = CNT_W + 1;
   localparam int MEM_DEPTH = 2 * BUF_SIZE;

   localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;

   localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CHAR   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_NONE   = 2'd2;

   localparam logic REQ_BYTE = 1'b0;
   localparam logic REQ_READ = 1'b1;

   typedef struct packed {
      logic capture;
      logic do_byte;
      logic emit_none;
      logic start_read;
      logic fetch;
      logic emit_char;
   } cmd_type;

   typedef struct packed {
      logic is_read;
      logic read_empty;
      logic out_free;
      logic last_char;
   } status_type;

endpackage

>>> rtl/slasm_ctrl.sv
// Controller state machine of the serial line assembler.
// Depends on slasm_pkg for the command and status bundles.
module slasm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  slasm_pkg::status_type status,
   output slasm_pkg::cmd_type    cmd
);
   import slasm_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_DECODE = 6'b000010,
      S_BYTE   = 6'b000100,
      S_EMPTY  = 6'b001000,
      S_FETCH  = 6'b010000,
      S_CHAR   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            priority if (!status.is_read) begin
               state_in = S_BYTE;
            end else if (status.read_empty) begin
               state_in = S_EMPTY;
            end else begin
               cmd.start_read = 1'b1;
               state_in       = S_FETCH;
            end
         end
         S_BYTE: begin
            if (status.out_free) begin
               cmd.do_byte = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_EMPTY: begin
            if (status.out_free) begin
               cmd.emit_none = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = S_CHAR;
         end
         S_CHAR: begin
            if (status.out_free) begin
               cmd.emit_char = 1'b1;
               state_in      = status.last_char ? S_IDLE : S_FETCH;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/slasm_dp.sv
// Datapath of the serial line assembler: request registers, the two-bank
// line store, line bookkeeping and the response register.
// Depends on slasm_pkg; driven by slasm_ctrl.
module slasm_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  slasm_pkg::cmd_type            cmd,
   output slasm_pkg::status_type         status,
   input  logic                          req_type,
   input  logic [slasm_pkg::BYTE_W-1:0]  req_rx_byte,
   input  logic [slasm_pkg::BYTE_W-1:0]  req_read_limit,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [slasm_pkg::KIND_W-1:0]  rsp_kind,
   output logic [slasm_pkg::BYTE_W-1:0]  rsp_out_char,
   output logic [slasm_pkg::LEN_W-1:0]   rsp_line_length,
   output logic                          rsp_line_ready,
   output logic                          rsp_last
);
   import slasm_pkg::*;

   // Captured request.
   logic              type_ff;
   logic [BYTE_W-1:0] byte_ff;
   logic [BYTE_W-1:0] limit_ff;

   // Line bookkeeping.
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]  nz_ff, nz_in;
   logic              zseen_ff, zseen_in;
   logic              bank_ff, bank_in;
   logic [CNT_W-1:0]  held_nz_ff, held_nz_in;
   logic              ready_ff, ready_in;

   // Read-out.
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  len_ff, len_in;

   // Line store.
   logic [BYTE_W-1:0] mem [MEM_DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;

   // Response register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [BYTE_W-1:0] char_ff, char_in;
   logic [LEN_W-1:0]  rlen_ff, rlen_in;
   logic              rrdy_ff, rrdy_in;
   logic              last_ff, last_in;
   logic              rsp_load;

   logic              is_eol;
   logic              publish;
   logic              append;
   logic [BYTE_W-1:0] cap;
   logic [CNT_W-1:0]  len_calc;

   assign is_eol  = (byte_ff == CH_LF) || (byte_ff == CH_CR);
   assign publish = is_eol && (fill_ff != '0) && !ready_ff;
   assign append  = !is_eol && (fill_ff < CNT_W'(BUF_SIZE - 1));

   // The delivered length is the count of leading non-zero characters, cut
   // to one less than the reader's buffer size; a zero limit acts as one.
   assign cap      = (limit_ff == '0) ? '0 : limit_ff - BYTE_W'(1);
   assign len_calc = (BYTE_W'(held_nz_ff) > cap) ? cap[CNT_W-1:0] : held_nz_ff;

   assign status.is_read    = (type_ff == REQ_READ);
   assign status.read_empty = !ready_ff || (len_calc == '0);
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;
   assign status.last_char  = ((idx_ff + CNT_W'(1)) == len_ff);

   assign wr_en   = cmd.do_byte && append;
   assign wr_addr = {bank_ff, fill_ff};
   // The finished line sits in the bank not being assembled.
   assign rd_addr = {~bank_ff, idx_ff};

   always_comb begin
      fill_in    = fill_ff;
      nz_in      = nz_ff;
      zseen_in   = zseen_ff;
      bank_in    = bank_ff;
      held_nz_in = held_nz_ff;
      ready_in   = ready_ff;
      idx_in     = idx_ff;
      len_in     = len_ff;
      if (cmd.do_byte) begin
         if (publish) begin
            held_nz_in = nz_ff;
            ready_in   = 1'b1;
            bank_in    = ~bank_ff;
            fill_in    = '0;
            nz_in      = '0;
            zseen_in   = 1'b0;
         end else if (append) begin
            fill_in = fill_ff + CNT_W'(1);
            if (byte_ff == CH_NUL) begin
               zseen_in = 1'b1;
            end else if (!zseen_ff) begin
               nz_in = nz_ff + CNT_W'(1);
            end
         end
      end
      if (cmd.emit_none || cmd.start_read) begin
         ready_in = 1'b0;
      end
      if (cmd.start_read) begin
         idx_in = '0;
         len_in = len_calc;
      end
      if (cmd.emit_char) begin
         idx_in = idx_ff + CNT_W'(1);
      end
   end

   assign rsp_load = cmd.do_byte || cmd.emit_none || cmd.emit_char;

   always_comb begin
      kind_in = kind_ff;
      char_in = char_ff;
      rlen_in = rlen_ff;
      rrdy_in = rrdy_ff;
      last_in = last_ff;
      if (cmd.do_byte) begin
         kind_in = KIND_STATUS;
         char_in = '0;
         rlen_in = '0;
         rrdy_in = ready_in;
         last_in = 1'b1;
      end else if (cmd.emit_none) begin
         kind_in = KIND_NONE;
         char_in = '0;
         rlen_in = '0;
         rrdy_in = 1'b0;
         last_in = 1'b1;
      end else if (cmd.emit_char) begin
         kind_in = KIND_CHAR;
         char_in = rd_data_ff;
         rlen_in = LEN_W'(len_ff);
         rrdy_in = 1'b0;
         last_in = status.last_char;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         nz_ff        <= '0;
         zseen_ff     <= 1'b0;
         bank_ff      <= 1'b0;
         held_nz_ff   <= '0;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         nz_ff        <= nz_in;
         zseen_ff     <= zseen_in;
         bank_ff      <= bank_in;
         held_nz_ff   <= held_nz_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff  <= req_type;
         byte_ff  <= req_rx_byte;
         limit_ff <= req_read_limit;
      end
      idx_ff  <= idx_in;
      len_ff  <= len_in;
      kind_ff <= kind_in;
      char_ff <= char_in;
      rlen_ff <= rlen_in;
      rrdy_ff <= rrdy_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= byte_ff;
      end
      if (cmd.fetch) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_out_char    = char_ff;
   assign rsp_line_length = rlen_ff;
   assign rsp_line_ready  = rrdy_ff;
   assign rsp_last        = last_ff;

endmodule

>>> rtl/serial_line_assembler_core.sv
// Serial line assembler. Each request is either a received byte or a read of
// the finished line. A byte is captured, decoded and, once the output is free,
// answered with its status response; a read is captured and decoded, and each
// character is then one read of the line store and one load of the response
// register once the output is free. One request is in flight at a time, but a
// new request is taken while the last response still waits in its register.
// Depends on slasm_pkg, slasm_ctrl and slasm_dp.
module serial_line_assembler_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_type,
   input  logic [slasm_pkg::BYTE_W-1:0]  req_rx_byte,
   input  logic [slasm_pkg::BYTE_W-1:0]  req_read_limit,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [slasm_pkg::KIND_W-1:0]  rsp_kind,
   output logic [slasm_pkg::BYTE_W-1:0]  rsp_out_char,
   output logic [slasm_pkg::LEN_W-1:0]   rsp_line_length,
   output logic                          rsp_line_ready,
   output logic                          rsp_last
);
   import slasm_pkg::*;

   cmd_type    cmd;
   status_type status;

   slasm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   slasm_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_type        (req_type),
      .req_rx_byte     (req_rx_byte),
      .req_read_limit  (req_read_limit),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_out_char    (rsp_out_char),
      .rsp_line_length (rsp_line_length),
      .rsp_line_ready  (rsp_line_ready),
      .rsp_last        (rsp_last)
   );

endmodule

>>> rtl/slasm_checker.sv
// Port-level checks for the serial line assembler, bound to the top level.
// Depends on slasm_pkg.
module slasm_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic                          req_type,
   input  logic [slasm_pkg::BYTE_W-1:0]  req_rx_byte,
   input  logic [slasm_pkg::BYTE_W-1:0]  req_read_limit,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [slasm_pkg::KIND_W-1:0]  rsp_kind,
   input  logic [slasm_pkg::BYTE_W-1:0]  rsp_out_char,
   input  logic [slasm_pkg::LEN_W-1:0]   rsp_line_length,
   input  logic                          rsp_line_ready,
   input  logic                          rsp_last
);
   import slasm_pkg::*;

   // A stalled response holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_out_char)
         && $stable(rsp_last))
      else $error("stalled response changed");

   // Only one request is worked on at a time.
   a_one_request: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while another is in progress");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_STATUS) |-> rsp_last && (rsp_line_length == '0))
      else $error("status response malformed");

   a_char_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_CHAR) |-> !rsp_line_ready && (rsp_line_length != '0))
      else $error("line character response malformed");

   a_none_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_NONE)
         |-> rsp_last && !rsp_line_ready && (rsp_out_char == '0) && (rsp_line_length == '0))
      else $error("empty reply malformed");

endmodule

bind serial_line_assembler_core slasm_checker u_slasm_checker (.*);
